// ===== src/cpf_pkg.sv =====
`default_nettype none
package cpf_pkg;

   localparam int MaxVertices = 16;
   localparam int MaxEdges    = 32;
   localparam int VtxW        = 4;
   localparam int VcntW       = 5;
   localparam int EdgeW       = 5;
   localparam int EdgeCntW    = 6;
   localparam int WeightW     = 12;
   localparam int EarlyW      = 20;
   localparam int LateW       = 21;
   localparam int DegW        = 6;

   // datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_COUNT, OP_INIT, OP_POP, OP_FWD, OP_CHECK,
      OP_BPOP, OP_BWD, OP_BWRITE, OP_VSEL, OP_EMIT, OP_VNEXT, OP_STATUS
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_done;    // edge scan reached edges loaded
      logic vtx_done;     // vertex scan reached vertex count
      logic stack_empty;
      logic ord_empty;
      logic sorted_all;   // every vertex landed in the order stack
      logic rsp_free;     // output register can take a word
   } stat_type;

endpackage
`default_nettype wire

// ===== src/cpf_ctrl.sv =====
`default_nettype none
module cpf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tlast,
   output logic                  req_tready,
   input  wire cpf_pkg::stat_type stat,
   output cpf_pkg::cmd_type      cmd
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_CLEAR  = 12'b000000000010,
      ST_COUNT  = 12'b000000000100,
      ST_INIT   = 12'b000000001000,
      ST_POP    = 12'b000000010000,
      ST_FWD    = 12'b000000100000,
      ST_CHECK  = 12'b000001000000,
      ST_BPOP   = 12'b000010000000,
      ST_BWD    = 12'b000100000000,
      ST_VSEL   = 12'b001000000000,
      ST_EMIT   = 12'b010000000000,
      ST_STATUS = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = cpf_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op = cpf_pkg::OP_LOAD;
               if (req_tlast) state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.op   = cpf_pkg::OP_CLEAR;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (stat.scan_done) state_in = ST_INIT;
            else cmd.op = cpf_pkg::OP_COUNT;
         end
         ST_INIT: begin
            if (stat.vtx_done) state_in = ST_POP;
            else cmd.op = cpf_pkg::OP_INIT;
         end
         ST_POP: begin
            if (stat.stack_empty) state_in = ST_CHECK;
            else begin
               cmd.op   = cpf_pkg::OP_POP;
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            if (stat.scan_done) state_in = ST_POP;
            else cmd.op = cpf_pkg::OP_FWD;
         end
         ST_CHECK: begin
            cmd.op   = cpf_pkg::OP_CHECK;
            state_in = stat.sorted_all ? ST_BPOP : ST_STATUS;
         end
         ST_BPOP: begin
            if (stat.ord_empty) state_in = ST_VSEL;
            else begin
               cmd.op   = cpf_pkg::OP_BPOP;
               state_in = ST_BWD;
            end
         end
         ST_BWD: begin
            if (stat.scan_done) begin
               cmd.op   = cpf_pkg::OP_BWRITE;
               state_in = ST_BPOP;
            end else cmd.op = cpf_pkg::OP_BWD;
         end
         ST_VSEL: begin
            if (stat.vtx_done) state_in = ST_STATUS;
            else begin
               cmd.op   = cpf_pkg::OP_VSEL;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.scan_done) begin
               cmd.op   = cpf_pkg::OP_VNEXT;
               state_in = ST_VSEL;
            end else if (stat.rsp_free) cmd.op = cpf_pkg::OP_EMIT;
         end
         ST_STATUS: begin
            if (stat.rsp_free) begin
               cmd.op   = cpf_pkg::OP_STATUS;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ===== src/cpf_datapath.sv =====
`default_nettype none
module cpf_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cpf_pkg::cmd_type              cmd,
   output cpf_pkg::stat_type                  stat,
   input  wire logic [cpf_pkg::VcntW-1:0]     n_used,
   input  wire logic [cpf_pkg::VtxW-1:0]      edge_src,
   input  wire logic [cpf_pkg::VtxW-1:0]      edge_dst,
   input  wire logic [cpf_pkg::WeightW-1:0]   edge_weight,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [cpf_pkg::VtxW-1:0]           crit_src,
   output logic [cpf_pkg::VtxW-1:0]           crit_dst,
   output logic [cpf_pkg::WeightW-1:0]        crit_weight,
   output logic                               is_status,
   output logic                               acyclic,
   output logic                               last_result
);

   localparam int VW = cpf_pkg::VtxW;
   localparam int LW = cpf_pkg::LateW;

   logic [VW-1:0]               src_ff    [cpf_pkg::MaxEdges];
   logic [VW-1:0]               dst_ff    [cpf_pkg::MaxEdges];
   logic [cpf_pkg::WeightW-1:0] wgt_ff    [cpf_pkg::MaxEdges];
   logic [cpf_pkg::DegW-1:0]    indeg_ff  [cpf_pkg::MaxVertices];
   logic [cpf_pkg::EarlyW-1:0]  early_ff  [cpf_pkg::MaxVertices];
   logic [LW-1:0]               late_ff   [cpf_pkg::MaxVertices];
   logic [VW-1:0]               work_ff   [cpf_pkg::MaxVertices];
   logic [VW-1:0]               order_ff  [cpf_pkg::MaxVertices];

   logic [cpf_pkg::EdgeCntW-1:0] edges_ff, e_ff;
   logic [cpf_pkg::VcntW-1:0]    i_ff, top_ff, ord_ff;
   logic                         ok_ff;
   logic [VW-1:0]                g_ff;
   logic [cpf_pkg::EarlyW-1:0]   eg_ff;
   logic signed [LW:0]           lg_ff;

   logic [VW-1:0]               cur_src, cur_dst, top_idx, ord_idx, nm1;
   logic [cpf_pkg::WeightW-1:0] cur_w;
   logic                        src_ok, dst_ok, hit, can_push, crit_hit, rsp_set;
   logic [cpf_pkg::VcntW-1:0]   top_dec, ord_dec, n_dec;
   logic [cpf_pkg::EarlyW:0]    fwd_sum;
   logic signed [LW:0]          bwd_t;

   assign cur_src  = src_ff[e_ff[cpf_pkg::EdgeW-1:0]];
   assign cur_dst  = dst_ff[e_ff[cpf_pkg::EdgeW-1:0]];
   assign cur_w    = wgt_ff[e_ff[cpf_pkg::EdgeW-1:0]];
   assign src_ok   = {1'b0, cur_src} < n_used;
   assign dst_ok   = {1'b0, cur_dst} < n_used;
   assign hit      = (cur_src == g_ff) && dst_ok;
   assign can_push = top_ff < cpf_pkg::VcntW'(cpf_pkg::MaxVertices);
   assign top_dec  = top_ff - 1'b1;
   assign ord_dec  = ord_ff - 1'b1;
   assign n_dec    = n_used - 1'b1;
   assign top_idx  = top_dec[VW-1:0];
   assign ord_idx  = ord_dec[VW-1:0];
   assign nm1      = n_dec[VW-1:0];
   assign fwd_sum  = {1'b0, eg_ff} + (cpf_pkg::EarlyW + 1)'(cur_w);
   assign bwd_t    = $signed({late_ff[cur_dst][LW-1], late_ff[cur_dst]})
                   - $signed({{(LW + 1 - cpf_pkg::WeightW){1'b0}}, cur_w});
   // zero slack: earliest start equals latest start
   assign crit_hit = hit && ($signed({2'b00, eg_ff}) == bwd_t);
   assign rsp_set  = ((cmd.op == cpf_pkg::OP_EMIT) && crit_hit) ||
                     (cmd.op == cpf_pkg::OP_STATUS);

   assign stat.scan_done   = (e_ff == edges_ff);
   assign stat.vtx_done    = (i_ff == n_used);
   assign stat.stack_empty = (top_ff == '0);
   assign stat.ord_empty   = (ord_ff == '0);
   assign stat.sorted_all  = (ord_ff == n_used);
   assign stat.rsp_free    = !rsp_tvalid || rsp_tready;

   // control counters, in-degree, earliest times and the rsp valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff   <= '0;
         e_ff       <= '0;
         i_ff       <= '0;
         top_ff     <= '0;
         ord_ff     <= '0;
         ok_ff      <= 1'b0;
         rsp_tvalid <= 1'b0;
         for (int v = 0; v < cpf_pkg::MaxVertices; v++) begin
            indeg_ff[v] <= '0;
            early_ff[v] <= '0;
         end
      end else begin
         if (rsp_set) rsp_tvalid <= 1'b1;
         else if (rsp_tvalid && rsp_tready) rsp_tvalid <= 1'b0;
         case (cmd.op)
            cpf_pkg::OP_LOAD: begin
               if (edges_ff < cpf_pkg::EdgeCntW'(cpf_pkg::MaxEdges))
                  edges_ff <= edges_ff + 1'b1;
            end
            cpf_pkg::OP_CLEAR: begin
               e_ff   <= '0;
               i_ff   <= '0;
               top_ff <= '0;
               ord_ff <= '0;
               for (int v = 0; v < cpf_pkg::MaxVertices; v++) begin
                  indeg_ff[v] <= '0;
                  early_ff[v] <= '0;
               end
            end
            cpf_pkg::OP_COUNT: begin
               if (src_ok && dst_ok) indeg_ff[cur_dst] <= indeg_ff[cur_dst] + 1'b1;
               e_ff <= e_ff + 1'b1;
            end
            cpf_pkg::OP_INIT: begin
               if (indeg_ff[i_ff[VW-1:0]] == '0 && can_push) top_ff <= top_ff + 1'b1;
               i_ff <= i_ff + 1'b1;
            end
            cpf_pkg::OP_POP: begin
               top_ff <= top_dec;
               if (ord_ff < cpf_pkg::VcntW'(cpf_pkg::MaxVertices)) ord_ff <= ord_ff + 1'b1;
               e_ff <= '0;
            end
            cpf_pkg::OP_FWD: begin
               if (hit) begin
                  if (indeg_ff[cur_dst] != '0) begin
                     indeg_ff[cur_dst] <= indeg_ff[cur_dst] - 1'b1;
                     if (indeg_ff[cur_dst] == cpf_pkg::DegW'(1) && can_push)
                        top_ff <= top_ff + 1'b1;
                  end
                  if (fwd_sum > {1'b0, early_ff[cur_dst]})
                     early_ff[cur_dst] <= fwd_sum[cpf_pkg::EarlyW-1:0];
               end
               e_ff <= e_ff + 1'b1;
            end
            cpf_pkg::OP_CHECK: begin
               ok_ff <= (ord_ff == n_used);
               i_ff  <= '0;
            end
            cpf_pkg::OP_BPOP: begin
               ord_ff <= ord_dec;
               e_ff   <= '0;
            end
            cpf_pkg::OP_BWD:   e_ff <= e_ff + 1'b1;
            cpf_pkg::OP_VSEL:  e_ff <= '0;
            cpf_pkg::OP_EMIT:  e_ff <= e_ff + 1'b1;
            cpf_pkg::OP_VNEXT: i_ff <= i_ff + 1'b1;
            cpf_pkg::OP_STATUS: edges_ff <= '0;
            default: ;
         endcase
      end
   end

   // payload: edge tables, stacks, latest times, output word
   always_ff @(posedge clock) begin
      case (cmd.op)
         cpf_pkg::OP_LOAD: begin
            if (edges_ff < cpf_pkg::EdgeCntW'(cpf_pkg::MaxEdges)) begin
               src_ff[edges_ff[cpf_pkg::EdgeW-1:0]] <= edge_src;
               dst_ff[edges_ff[cpf_pkg::EdgeW-1:0]] <= edge_dst;
               wgt_ff[edges_ff[cpf_pkg::EdgeW-1:0]] <= edge_weight;
            end
         end
         cpf_pkg::OP_INIT: begin
            if (indeg_ff[i_ff[VW-1:0]] == '0 && can_push)
               work_ff[top_ff[VW-1:0]] <= i_ff[VW-1:0];
         end
         cpf_pkg::OP_POP: begin
            g_ff  <= work_ff[top_idx];
            eg_ff <= early_ff[work_ff[top_idx]];
            if (ord_ff < cpf_pkg::VcntW'(cpf_pkg::MaxVertices))
               order_ff[ord_ff[VW-1:0]] <= work_ff[top_idx];
         end
         cpf_pkg::OP_FWD: begin
            if (hit && indeg_ff[cur_dst] == cpf_pkg::DegW'(1) && can_push)
               work_ff[top_ff[VW-1:0]] <= cur_dst;
         end
         cpf_pkg::OP_CHECK: begin
            for (int v = 0; v < cpf_pkg::MaxVertices; v++)
               late_ff[v] <= {1'b0, early_ff[nm1]};
         end
         cpf_pkg::OP_BPOP: begin
            g_ff  <= order_ff[ord_idx];
            lg_ff <= $signed({late_ff[order_ff[ord_idx]][LW-1], late_ff[order_ff[ord_idx]]});
         end
         cpf_pkg::OP_BWD: begin
            if (hit && bwd_t < lg_ff) lg_ff <= bwd_t;
         end
         cpf_pkg::OP_BWRITE: late_ff[g_ff] <= lg_ff[LW-1:0];
         cpf_pkg::OP_VSEL: begin
            g_ff  <= i_ff[VW-1:0];
            eg_ff <= early_ff[i_ff[VW-1:0]];
         end
         cpf_pkg::OP_EMIT: begin
            if (crit_hit) begin
               crit_src    <= cur_src;
               crit_dst    <= cur_dst;
               crit_weight <= cur_w;
               is_status   <= 1'b0;
               acyclic     <= 1'b0;
               last_result <= 1'b0;
            end
         end
         cpf_pkg::OP_STATUS: begin
            crit_src    <= '0;
            crit_dst    <= '0;
            crit_weight <= '0;
            is_status   <= 1'b1;
            acyclic     <= ok_ff;
            last_result <= 1'b1;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/critical_path_finder_core.sv =====
`default_nettype none
// channel  dir  tdata (low bit first)                tuser      tlast
// req      in   edge_src, edge_dst, edge_weight, pad  -          last_edge
// rsp      out  crit_src, crit_dst, crit_weight,      is_status  last_result
//               acyclic, pad
// csr      in   vertex_count (write enable + data, no read-back)
//
// Edge words load one per cycle while req_tready is high. After the last edge an
// acyclic run clears state, counts in-degrees, seeds the stack, then runs the
// forward sort, the backward pass and the edge emit, each paced by the edge-table
// scans of the shared datapath, and any rsp stall lengthens it; a cyclic run stops
// after the forward sort. req_tready is low for the run.
// Synchronous reset clears counters and sets vertex_count to 16.
// A stalled rsp word holds the emit scan; output data waits in a register.
module critical_path_finder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // edge_src[3:0], edge_dst[7:4], edge_weight[19:8]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // crit_src[3:0], crit_dst[7:4], crit_weight[19:8],
                                         // acyclic[20]
   output logic             rsp_tuser,   // is_status
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);

   cpf_pkg::cmd_type  cmd;
   cpf_pkg::stat_type stat;

   logic [cpf_pkg::VcntW-1:0]   vertex_count_ff;
   logic [cpf_pkg::VcntW-1:0]   n_used;
   logic [cpf_pkg::VtxW-1:0]    crit_src, crit_dst;
   logic [cpf_pkg::WeightW-1:0] crit_weight;
   logic                        acyclic;

   always_ff @(posedge clock) begin
      if (reset) vertex_count_ff <= cpf_pkg::VcntW'(cpf_pkg::MaxVertices);
      else if (csr_wr_en) vertex_count_ff <= csr_wr_data;
   end

   // zero acts as one vertex, anything above the table as the full table
   always_comb begin
      if (vertex_count_ff == '0) n_used = cpf_pkg::VcntW'(1);
      else if (vertex_count_ff > cpf_pkg::VcntW'(cpf_pkg::MaxVertices))
         n_used = cpf_pkg::VcntW'(cpf_pkg::MaxVertices);
      else n_used = vertex_count_ff;
   end

   cpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cpf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .n_used      (n_used),
      .edge_src    (req_tdata[3:0]),
      .edge_dst    (req_tdata[7:4]),
      .edge_weight (req_tdata[19:8]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .crit_src    (crit_src),
      .crit_dst    (crit_dst),
      .crit_weight (crit_weight),
      .is_status   (rsp_tuser),
      .acyclic     (acyclic),
      .last_result (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, acyclic, crit_weight, crit_dst, crit_src};

endmodule
`default_nettype wire
